[rtl/core/table_driven_dfa_engine_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the DFA engine checker
// Shared property wrappers clocked on clk, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef TABLE_DRIVEN_DFA_ENGINE_TOP_ASSERT_SVH
`define TABLE_DRIVEN_DFA_ENGINE_TOP_ASSERT_SVH

// Property checked only while out of reset
`define TDFA_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included
`define TDFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tdfa_pkg.sv]
// ----------------------------------------------------------------------------
// tdfa_pkg
// Shared widths, codes and types of the table-driven DFA engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tdfa_pkg;

  // Field widths
  localparam int OP_W       = 3;
  localparam int SYM_W      = 8;
  localparam int STATE_W    = 4;
  localparam int STATUS_W   = 2;
  localparam int MASK_W     = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Default geometry
  localparam int NUM_STATES_DEF  = 16;
  localparam int NUM_SYMBOLS_DEF = 256;

  // Item opcodes (carried on in_tuser)
  localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
  localparam logic [OP_W-1:0] OP_MARK    = 3'd1;
  localparam logic [OP_W-1:0] OP_FEED    = 3'd2;
  localparam logic [OP_W-1:0] OP_END     = 3'd3;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SYM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_TRANS = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK = 1'd1;

  // One transition table entry
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] dest;
  } tdfa_entry_t;

endpackage

`default_nettype wire

[rtl/core/tdfa_trans_mem.sv]
// ----------------------------------------------------------------------------
// tdfa_trans_mem
// Transition table RAM, one write and one registered read port, with a
// clearing pass after reset that marks every entry invalid.
// ----------------------------------------------------------------------------
`default_nettype none

module tdfa_trans_mem
  import tdfa_pkg::*;
#(
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output tdfa_entry_t            rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire tdfa_entry_t       wr_data,
  output logic                   clearing
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = {ADDR_W{1'b1}};

  tdfa_entry_t       mem [2**ADDR_W];
  tdfa_entry_t       rd_data_r;
  logic              clr_r;
  logic              clr_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_addr_nxt;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  tdfa_entry_t       wdata;

  // Clearing sweep control
  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Write port shared by the sweep and table loads
  always_comb begin
    we    = wr_en;
    waddr = wr_addr;
    wdata = wr_data;
    if (clr_r) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;

endmodule

`default_nettype wire

[rtl/core/table_driven_dfa_engine_top.sv]
// Path: lookup register (table read), then resolve into the output register.
// Throughput: 1 item per cycle for load, mark, end, restart and unknown ops
//   while the result side takes beats; a feed holds off the next item because
//   its table read needs the state that the feed before it resolves.
// Reset: synchronous, active low; a clearing pass over all NUM_STATES*NUM_SYMBOLS
//   table entries (4096 at default sizes, powers of two) wipes table and alphabet.
// ----------------------------------------------------------------------------
// table_driven_dfa_engine_top
// Programmable DFA: transition table and alphabet bitmap in RAMs,
// one lookup stage followed by a resolve stage and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module table_driven_dfa_engine_top
  import tdfa_pkg::*;
#(
  parameter int NUM_STATES  = NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // symbol[7:0], from_state[11:8],
                                                // next_state[15:12]
  input  wire logic [OP_W-1:0]       in_tuser,  // op[2:0]
  // Result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata, // current_state[3:0], accepted[4],
                                                // status[6:5], zero[7]
  // Register write port
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STW    = $clog2(NUM_STATES);
  localparam int SYW    = $clog2(NUM_SYMBOLS);
  localparam int ADDR_W = STW + SYW;

  // Input field split
  logic [SYM_W-1:0]   in_sym;
  logic [STATE_W-1:0] in_from;
  logic [STATE_W-1:0] in_dest;
  logic               in_acc;

  assign in_sym  = in_tdata[SYM_W-1:0];
  assign in_from = in_tdata[SYM_W+STATE_W-1:SYM_W];
  assign in_dest = in_tdata[SYM_W+2*STATE_W-1:SYM_W+STATE_W];

  // Registers
  logic [STATE_W-1:0]     start_state_r;
  logic [MASK_W-1:0]      accept_mask_r;
  logic [STATE_W-1:0]     cur_state_r;
  logic [STATE_W-1:0]     cur_state_nxt;
  logic [STATUS_W-1:0]    err_r;
  logic [STATUS_W-1:0]    err_nxt;

  logic                   alph_mem [2**SYW];
  logic                   alph_rd_r;
  logic [SYW-1:0]         alph_clr_addr_r;

  logic                   s1_valid_r;
  logic [OP_W-1:0]        s1_op_r;
  logic                   s1_sym_ok_r;
  logic                   s1_state_ok_r;

  logic                   out_valid_r;
  logic [STATE_W-1:0]     out_state_r;
  logic                   out_acc_r;
  logic [STATUS_W-1:0]    out_status_r;

  logic                   s1_adv;
  logic                   clearing;
  tdfa_entry_t            rd_entry;
  tdfa_entry_t            wr_entry;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic [STATE_W-1:0]     look_state;
  logic                   sym_in_range;
  logic                   look_state_ok;
  logic                   res_acc;
  logic [STATUS_W-1:0]    res_status;

  // Register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      accept_mask_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_STATE: start_state_r <= cfg_data[STATE_W-1:0];
        REG_ACCEPT_MASK: accept_mask_r <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: a feed in the lookup stage blocks the next item
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clearing && (!s1_valid_r || (s1_adv && s1_op_r != OP_FEED));
  assign in_acc    = in_tvalid && in_tready;

  // State used for the lookup: forward the start state past an end or restart
  assign look_state    = (s1_valid_r && (s1_op_r == OP_END || s1_op_r == OP_RESTART)) ?
                         start_state_r : cur_state_r;
  assign look_state_ok = 32'(look_state) < NUM_STATES;
  assign sym_in_range  = 32'(in_sym) < NUM_SYMBOLS;
  assign rd_addr       = {STW'(look_state), SYW'(in_sym)};

  // Table load goes straight to RAM at accept
  assign wr_en = in_acc && in_tuser == OP_LOAD && sym_in_range &&
                 32'(in_from) < NUM_STATES && 32'(in_dest) < NUM_STATES;
  assign wr_addr        = {STW'(in_from), SYW'(in_sym)};
  assign wr_entry.valid = 1'b1;
  assign wr_entry.dest  = in_dest;

  tdfa_trans_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (rd_addr),
    .rd_data  (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_entry),
    .clearing (clearing)
  );

  // Alphabet clear address, sweeps during the table clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alph_clr_addr_r <= '0;
    end else if (clearing) begin
      alph_clr_addr_r <= alph_clr_addr_r + 1'b1;
    end
  end

  // Alphabet RAM: marked at accept, read at accept for the lookup stage
  always_ff @(posedge clk) begin
    if (clearing) begin
      alph_mem[alph_clr_addr_r] <= 1'b0;
    end else if (in_acc && in_tuser == OP_MARK && sym_in_range) begin
      alph_mem[SYW'(in_sym)] <= 1'b1;
    end
    if (in_acc) begin
      alph_rd_r <= alph_mem[SYW'(in_sym)];
    end
  end

  // Lookup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r       <= in_tuser;
      s1_sym_ok_r   <= sym_in_range;
      s1_state_ok_r <= look_state_ok;
    end
  end

  // Resolve stage
  always_comb begin
    cur_state_nxt = cur_state_r;
    err_nxt       = err_r;
    res_acc       = 1'b0;
    res_status    = err_r;
    case (s1_op_r)
      OP_FEED: begin
        if (err_r == ST_OK) begin
          if (!s1_sym_ok_r || !alph_rd_r) begin
            err_nxt = ST_NO_SYM;
          end else if (!s1_state_ok_r || !rd_entry.valid) begin
            err_nxt = ST_NO_TRANS;
          end else begin
            cur_state_nxt = rd_entry.dest;
          end
        end
        res_status = err_nxt;
      end
      OP_END: begin
        res_acc       = (err_r == ST_OK) && accept_mask_r[cur_state_r];
        err_nxt       = ST_OK;
        cur_state_nxt = start_state_r;
      end
      OP_RESTART: begin
        err_nxt       = ST_OK;
        cur_state_nxt = start_state_r;
        res_status    = ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r <= '0;
      err_r       <= ST_OK;
    end else if (s1_adv) begin
      cur_state_r <= cur_state_nxt;
      err_r       <= err_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_state_r  <= cur_state_nxt;
      out_acc_r    <= res_acc;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_status_r, out_acc_r, out_state_r};

endmodule

`default_nettype wire

[rtl/core/tdfa_checker.sv]
// ----------------------------------------------------------------------------
// tdfa_checker
// Port-level checks of the DFA engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "table_driven_dfa_engine_top_assert.svh"

module tdfa_checker
  import tdfa_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [OP_W-1:0]       in_tuser,  // op
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata  // current_state, accepted, status
);

  // Stalled result beat holds
  `TDFA_ASSERT_ON(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // No input taken right after reset: table is being cleared
  `TDFA_ASSERT_ALWAYS(a_clear_after_rst, !rst_n |=> !in_tready, "input ready during table clear")

  // A feed beat blocks input in the cycle after it is taken
  `TDFA_ASSERT_ON(a_feed_gap, in_tvalid && in_tready && in_tuser == OP_FEED |=> !in_tready, "input taken right behind a feed")

  // Acceptance only reported with clean status
  `TDFA_ASSERT_ON(a_acc_clean, out_tvalid && out_tdata[4] |-> out_tdata[6:5] == ST_OK, "accepted with error status")

  // Status is always a defined code
  `TDFA_ASSERT_ON(a_status_code, out_tvalid |-> out_tdata[6:5] == ST_OK || out_tdata[6:5] == ST_NO_SYM || out_tdata[6:5] == ST_NO_TRANS, "undefined status code")

endmodule

bind table_driven_dfa_engine_top tdfa_checker u_tdfa_checker (.*);

`default_nettype wire

[bench/dfa_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DFA engine scoreboard
// Watches the item, result and register channels of the DFA engine, tracks
// the automaton state, table, alphabet and sticky error on its own, and
// checks every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module dfa_checker
  import tdfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_pending
);

  localparam int TBL_DEPTH = NUM_STATES_DEF * NUM_SYMBOLS_DEF;

  typedef struct packed {
    logic [STATE_W-1:0]  state;
    logic                accepted;
    logic [STATUS_W-1:0] status;
  } dfa_result_t;

  // Shadow copy of the engine
  tdfa_entry_t         trans_tbl [TBL_DEPTH];
  logic                in_alphabet [NUM_SYMBOLS_DEF];
  logic [STATE_W-1:0]  cur_state;
  logic [STATUS_W-1:0] err_code;
  logic [STATE_W-1:0]  start_state;
  logic [MASK_W-1:0]   accept_mask;
  dfa_result_t         expected_q [$];

  // Apply one item to the shadow automaton and return what it reports
  function automatic dfa_result_t advance_dfa(input logic [OP_W-1:0]    op,
                                              input logic [SYM_W-1:0]   sym,
                                              input logic [STATE_W-1:0] src,
                                              input logic [STATE_W-1:0] dst);
    dfa_result_t res;
    res.accepted = 1'b0;
    case (op)
      OP_LOAD: begin
        trans_tbl[{src, sym}].valid = 1'b1;
        trans_tbl[{src, sym}].dest  = dst;
        res.status = err_code;
      end
      OP_MARK: begin
        in_alphabet[sym] = 1'b1;
        res.status = err_code;
      end
      OP_FEED: begin
        // an aborted string ignores further symbols
        if (err_code == ST_OK) begin
          if (!in_alphabet[sym])
            err_code = ST_NO_SYM;
          else if (trans_tbl[{cur_state, sym}].valid)
            cur_state = trans_tbl[{cur_state, sym}].dest;
          else
            err_code = ST_NO_TRANS;
        end
        res.status = err_code;
      end
      OP_END: begin
        res.status   = err_code;
        res.accepted = (err_code == ST_OK) && accept_mask[cur_state];
        err_code     = ST_OK;
        cur_state    = start_state;
      end
      OP_RESTART: begin
        err_code   = ST_OK;
        cur_state  = start_state;
        res.status = ST_OK;
      end
      default: res.status = err_code;
    endcase
    res.state = cur_state;
    return res;
  endfunction

  // Track beats on all three channels; items before results in one edge
  always @(posedge clk) begin
    dfa_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < TBL_DEPTH; i++) trans_tbl[i] = '0;
      for (int i = 0; i < NUM_SYMBOLS_DEF; i++) in_alphabet[i] = 1'b0;
      cur_state   = '0;
      err_code    = ST_OK;
      start_state = '0;
      accept_mask = '0;
      fail_count  = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_STATE: start_state = cfg_data[STATE_W-1:0];
          REG_ACCEPT_MASK: accept_mask = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(advance_dfa(in_tuser, in_tdata[SYM_W-1:0],
                                         in_tdata[SYM_W +: STATE_W],
                                         in_tdata[SYM_W+STATE_W +: STATE_W]));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual 0x%02h",
                   $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[3:0] !== want.state) begin
            $display("%0t: current_state mismatch, expected %0d, actual %0d",
                     $time, want.state, out_tdata[3:0]);
            fail_count++;
          end
          if (out_tdata[4] !== want.accepted) begin
            $display("%0t: accepted mismatch, expected %0d, actual %0d",
                     $time, want.accepted, out_tdata[4]);
            fail_count++;
          end
          if (out_tdata[6:5] !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_tdata[6:5]);
            fail_count++;
          end
          if (out_tdata[7] !== 1'b0) begin
            $display("%0t: pad bit mismatch, expected 0, actual %0d",
                     $time, out_tdata[7]);
            fail_count++;
          end
        end
      end
    end
    results_pending = expected_q.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DFA engine testbench
// Programs transition tables and alphabets, feeds strings framed by end and
// restart items under several start-state and accepting-mask settings, with
// random gaps on the item side and random stalls on the result side.
// ----------------------------------------------------------------------------

module testbench;
  import tdfa_pkg::*;

  localparam int              ITEM_TARGET   = 1650;
  localparam int              POOL_SIZE     = 6;
  localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // symbol[7:0], from_state[11:8],
                                            // next_state[15:12]
  logic [OP_W-1:0]       in_tuser   = '0;   // op[2:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // current_state[3:0], accepted[4],
                                            // status[6:5], zero[7]
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int               fail_count;
  int               results_pending;
  logic             no_idle    = 1'b0;  // both sides run back to back
  int               items_sent = 0;
  int               stall_left = 0;
  logic [SYM_W-1:0] sym_pool [$];

  table_driven_dfa_engine_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dfa_checker scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  always #5 clk = ~clk;

  // Result side: random stall after each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        stall_left = no_idle ? 0 : $urandom_range(0, 19);
        if (stall_left != 0) out_tready <= 1'b0;
      end
    end else if (stall_left == 0) begin
      out_tready <= 1'b1;
    end else begin
      stall_left--;
    end
  end

  // Send one item beat after a random gap; valid is left high on return
  task automatic push_item(input logic [OP_W-1:0]    op,
                           input logic [SYM_W-1:0]   sym,
                           input logic [STATE_W-1:0] src,
                           input logic [STATE_W-1:0] dst);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {dst, src, sym};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Hold the item side until every result is back and the pipe is empty
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers in one burst so valid is never dropped and raised at once
  task automatic set_dfa_regs(input logic [STATE_W-1:0] start,
                              input logic [MASK_W-1:0]  mask);
    cfg_valid <= 1'b1;
    cfg_index <= REG_START_STATE;
    cfg_data  <= CFG_DATA_W'(start);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_ACCEPT_MASK;
    cfg_data  <= CFG_DATA_W'(mask);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly symbols of the current working alphabet, sometimes anything
  function automatic logic [SYM_W-1:0] pick_symbol();
    if (sym_pool.size() != 0 && $urandom_range(0, 99) < 85)
      return sym_pool[$urandom_range(0, sym_pool.size() - 1)];
    return SYM_W'($urandom);
  endfunction

  // Fresh working alphabet, table mostly filled in over it
  task automatic program_phase();
    logic [SYM_W-1:0] sym;
    sym_pool.delete();
    repeat (POOL_SIZE) begin
      sym = SYM_W'($urandom);
      sym_pool.push_back(sym);
      push_item(OP_MARK, sym, STATE_W'($urandom), STATE_W'($urandom));
    end
    for (int s = 0; s < NUM_STATES_DEF; s++)
      foreach (sym_pool[k])
        if ($urandom_range(0, 3) != 0)
          push_item(OP_LOAD, sym_pool[k], STATE_W'(s), STATE_W'($urandom));
  endtask

  // One string: optional restart, a few symbols, usually an end
  task automatic run_string();
    int len;
    if ($urandom_range(0, 9) == 0)
      push_item(OP_RESTART, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
    len = $urandom_range(0, 8);
    repeat (len)
      push_item(OP_FEED, pick_symbol(), STATE_W'($urandom), STATE_W'($urandom));
    if ($urandom_range(0, 9) != 0)
      push_item(OP_END, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
  endtask

  // Stray items between strings
  task automatic push_noise();
    case ($urandom_range(0, 5))
      0, 1: push_item(OP_LOAD, pick_symbol(), STATE_W'($urandom), STATE_W'($urandom));
      2:    push_item(OP_MARK, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
      3:    push_item(OP_FEED, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
      4:    push_item(OP_RESTART, SYM_W'($urandom), STATE_W'($urandom),
                      STATE_W'($urandom));
      default:
        push_item(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                  SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    int phase;
    phase = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: states 0 and 15 accepting, start in 0
    set_dfa_regs(4'd0, 16'h8001);
    push_item(OP_FEED, 8'h00, 4'h0, 4'hF);           // empty alphabet
    push_item(OP_FEED, 8'hFF, 4'hF, 4'h0);           // ignored, error sticks
    push_item(OP_UNUSED_LO, 8'hFF, 4'hF, 4'hF);
    push_item(OP_UNUSED_MID, 8'h00, 4'h0, 4'h0);
    push_item(OP_UNUSED_HI, 8'hA5, 4'h5, 4'hA);
    push_item(OP_END, 8'h00, 4'h0, 4'h0);            // reports and clears error
    push_item(OP_MARK, 8'h00, 4'h0, 4'h0);
    push_item(OP_MARK, 8'hFF, 4'hF, 4'hF);
    push_item(OP_FEED, 8'h00, 4'h0, 4'h0);           // no transition loaded
    push_item(OP_LOAD, 8'h00, 4'h0, 4'hF);           // load while error pending
    push_item(OP_RESTART, 8'h00, 4'h0, 4'h0);        // clears error
    push_item(OP_LOAD, 8'hFF, 4'hF, 4'h0);
    push_item(OP_LOAD, 8'hFF, 4'h0, 4'h5);
    push_item(OP_LOAD, 8'hFF, 4'h0, 4'hF);           // overwrites the one above
    push_item(OP_FEED, 8'h00, 4'h0, 4'h0);           // 0 -> 15
    push_item(OP_END, 8'h00, 4'h0, 4'h0);            // accepted in 15
    push_item(OP_FEED, 8'hFF, 4'h0, 4'h0);           // 0 -> 15 after reload
    push_item(OP_FEED, 8'hFF, 4'h0, 4'h0);           // 15 -> 0
    push_item(OP_END, 8'h00, 4'h0, 4'h0);            // accepted in 0
    push_item(OP_FEED, 8'h00, 4'h0, 4'h0);           // 0 -> 15
    push_item(OP_FEED, 8'h00, 4'h0, 4'h0);           // missing from 15
    push_item(OP_END, 8'h00, 4'h0, 4'h0);            // accepting state, but error
    drain_results();

    // New start state only applies at the next end or restart
    set_dfa_regs(4'hF, 16'hFFFF);
    push_item(OP_FEED, 8'hFF, 4'h0, 4'h0);
    push_item(OP_RESTART, 8'h00, 4'h0, 4'h0);
    push_item(OP_END, 8'h00, 4'h0, 4'h0);

    // Random phases, each under its own register setting
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      case (phase % 4)
        0: set_dfa_regs(4'h0, 16'h0000);
        1: set_dfa_regs(4'hF, 16'hFFFF);
        default: set_dfa_regs(STATE_W'($urandom), MASK_W'($urandom));
      endcase
      no_idle = (phase % 3 == 2);
      program_phase();
      repeat (40) begin
        if (items_sent >= ITEM_TARGET) break;
        if ($urandom_range(0, 6) == 0) push_noise();
        else run_string();
      end
      phase++;
    end
    no_idle = 1'b0;
    drain_results();

    if (fail_count == 0 && results_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/tdfa_pkg.sv
rtl/core/tdfa_trans_mem.sv
rtl/core/table_driven_dfa_engine_top.sv
rtl/core/tdfa_checker.sv
bench/dfa_checker.sv
bench/testbench.sv
